// ===== src/vec2_length_limit_defines.svh =====
// Assertion macros used by the vec2_length_limit checker
`ifndef VEC2_LENGTH_LIMIT_DEFINES_SVH
`define VEC2_LENGTH_LIMIT_DEFINES_SVH

// same-cycle implication, reset gated
`define VLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset gated
`define VLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/vll_pkg.sv =====
// Types and constants of the 2D vector length limiter
`default_nettype none
package vll_pkg;
	localparam int CW        = 32;
	localparam int LIM_W     = 31;
	localparam int SQ_W      = 2 * CW;
	localparam int LSQ_W     = 2 * LIM_W;
	localparam int NUM_W     = CW + LIM_W;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;

	localparam logic [LIM_W-1:0] MAX_RESET   = {LIM_W{1'b1}};
	localparam logic [LSQ_W-1:0] MAXSQ_RESET = LSQ_W'(64'h3FFF_FFFF_0000_0001);

	typedef enum logic [1:0] {
		ACT_KEEP   = 2'd0,
		ACT_SHRINK = 2'd1,
		ACT_GROW   = 2'd2,
		ACT_ZERO   = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_LENGTH = 8'd0,
		REG_MIN_LENGTH = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          nx;
		logic          ny;
		action_t       act;
	} item_t;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		action_t       act;
		logic          sat;
	} res_t;
endpackage
`default_nettype wire

// ===== src/vll_ifs.sv =====
// Request channels of the vector length limiter: input, result and register write
`default_nettype none
interface vll_in_if import vll_pkg::*;;
	logic          valid;
	logic          ready;
	logic [CW-1:0] in_x;
	logic [CW-1:0] in_y;
	modport source (output valid, in_x, in_y, input ready);
	modport sink (input valid, in_x, in_y, output ready);
endinterface

interface vll_out_if import vll_pkg::*;;
	logic          valid;
	logic          ready;
	logic [CW-1:0] out_x;
	logic [CW-1:0] out_y;
	action_t       action;
	logic          saturated;
	modport source (output valid, out_x, out_y, action, saturated, input ready);
	modport sink (input valid, out_x, out_y, action, saturated, output ready);
endinterface

interface vll_cfg_if import vll_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/vec2_length_limit.sv =====
// Top level of the 2D vector length limiter
// One vector enters per cycle while the skid entry is empty and passes through
// five stages of abs, square, sum, limit compare and numerator product, 32
// stages of a square root that settles one root bit per stage, 32 stages of a
// pair of dividers that settle one quotient bit per stage, and the output
// register. A two-entry output buffer lets the input keep taking requests when
// the output stalls, until a result waits in the skid entry. Components scale
// by limit/floor(sqrt(x*x+y*y)) rounded toward zero; a zero vector below the
// minimum passes through with action 3. Write the limits only while no
// request is in flight; the squared limits follow in the cycle after a write.
`default_nettype none
module vec2_length_limit import vll_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	vll_in_if.sink    vec_in,
	vll_out_if.source vec_out,
	vll_cfg_if.sink   cfg
);
	localparam int RT_W  = SQ_W + 2;
	localparam int DIV_W = NUM_W + 1;
	localparam logic [CW-1:0] HALF = CW'(1) << (CW - 1);

	logic [LIM_W-1:0] max_q, min_q;
	logic [LSQ_W-1:0] maxsq_q, minsq_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_RESET;
			min_q   <= '0;
			maxsq_q <= MAXSQ_RESET;
			minsq_q <= '0;
		end else begin
			maxsq_q <= LSQ_W'(max_q) * LSQ_W'(max_q);
			minsq_q <= LSQ_W'(min_q) * LSQ_W'(min_q);
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_MAX_LENGTH: max_q <= cfg.data[LIM_W-1:0];
					REG_MIN_LENGTH: min_q <= cfg.data[LIM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	logic en;
	logic skid_vld_q, out_vld_q;
	res_t skid_data_q, out_data_q;

	assign en           = !skid_vld_q;
	assign vec_in.ready = en;

	// front stages
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [CW-1:0] mx_s1, my_s1, mx_s2, my_s2, mx_s3, my_s3, mx_s4, my_s4;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sum_s3, sum_s4, sum_s5;
	logic [LIM_W-1:0] lim_s4;
	logic [NUM_W-1:0] numx_s5, numy_s5;
	logic [CW-1:0] mx_c, my_c;
	logic over_c, under_c;
	action_t act_c;

	assign mx_c = vec_in.in_x[CW-1] ? (~vec_in.in_x + CW'(1)) : vec_in.in_x;
	assign my_c = vec_in.in_y[CW-1] ? (~vec_in.in_y + CW'(1)) : vec_in.in_y;

	always_comb begin
		over_c  = sum_s3 > SQ_W'(maxsq_q);
		under_c = sum_s3 < SQ_W'(minsq_q);
		if (over_c)
			act_c = ACT_SHRINK;
		else if (under_c && sum_s3 == '0)
			act_c = ACT_ZERO;
		else if (under_c)
			act_c = ACT_GROW;
		else
			act_c = ACT_KEEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vec_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1.x   <= vec_in.in_x;
			it_s1.y   <= vec_in.in_y;
			it_s1.nx  <= vec_in.in_x[CW-1];
			it_s1.ny  <= vec_in.in_y[CW-1];
			it_s1.act <= ACT_KEEP;
			mx_s1     <= mx_c;
			my_s1     <= my_c;

			it_s2  <= it_s1;
			mx_s2  <= mx_s1;
			my_s2  <= my_s1;
			sqx_s2 <= SQ_W'(mx_s1) * SQ_W'(mx_s1);
			sqy_s2 <= SQ_W'(my_s1) * SQ_W'(my_s1);

			it_s3  <= it_s2;
			mx_s3  <= mx_s2;
			my_s3  <= my_s2;
			sum_s3 <= sqx_s2 + sqy_s2;

			it_s4  <= '{x: it_s3.x, y: it_s3.y, nx: it_s3.nx, ny: it_s3.ny, act: act_c};
			mx_s4  <= mx_s3;
			my_s4  <= my_s3;
			sum_s4 <= sum_s3;
			lim_s4 <= over_c ? max_q : min_q;

			it_s5   <= it_s4;
			sum_s5  <= sum_s4;
			numx_s5 <= NUM_W'(mx_s4) * NUM_W'(lim_s4);
			numy_s5 <= NUM_W'(my_s4) * NUM_W'(lim_s4);
		end
	end

	// square root, one root bit per stage
	logic             sr_vld_s  [CW];
	item_t            sr_it_s   [CW];
	logic [SQ_W-1:0]  sr_rem_s  [CW];
	logic [CW-1:0]    sr_root_s [CW];
	logic [NUM_W-1:0] sr_numx_s [CW];
	logic [NUM_W-1:0] sr_numy_s [CW];

	for (genvar k = 0; k < CW; k++) begin : g_sqrt
		localparam int B = CW - 1 - k;
		logic             vld_i;
		item_t            it_i;
		logic [SQ_W-1:0]  rem_i;
		logic [CW-1:0]    root_i;
		logic [NUM_W-1:0] numx_i, numy_i;
		logic [RT_W-1:0]  trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_i  = vld_s5;
			assign it_i   = it_s5;
			assign rem_i  = sum_s5;
			assign root_i = '0;
			assign numx_i = numx_s5;
			assign numy_i = numy_s5;
		end else begin : g_next
			assign vld_i  = sr_vld_s[k-1];
			assign it_i   = sr_it_s[k-1];
			assign rem_i  = sr_rem_s[k-1];
			assign root_i = sr_root_s[k-1];
			assign numx_i = sr_numx_s[k-1];
			assign numy_i = sr_numy_s[k-1];
		end

		assign trial = (RT_W'(root_i) << (B + 1)) | (RT_W'(1) << (2 * B));
		assign ge    = RT_W'(rem_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sr_vld_s[k] <= 1'b0;
			else if (en)
				sr_vld_s[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sr_it_s[k]   <= it_i;
				sr_numx_s[k] <= numx_i;
				sr_numy_s[k] <= numy_i;
				sr_rem_s[k]  <= ge ? (rem_i - trial[SQ_W-1:0]) : rem_i;
				sr_root_s[k] <= ge ? (root_i | (CW'(1) << B)) : root_i;
			end
		end
	end

	// two dividers sharing the root as divisor, one quotient bit per stage
	logic             dv_vld_s [CW];
	item_t            dv_it_s  [CW];
	logic [CW-1:0]    dv_len_s [CW];
	logic [NUM_W-1:0] dv_rx_s  [CW];
	logic [NUM_W-1:0] dv_ry_s  [CW];
	logic [CW-1:0]    dv_qx_s  [CW];
	logic [CW-1:0]    dv_qy_s  [CW];

	for (genvar k = 0; k < CW; k++) begin : g_div
		localparam int B = CW - 1 - k;
		logic             vld_i;
		item_t            it_i;
		logic [CW-1:0]    len_i, qx_i, qy_i;
		logic [NUM_W-1:0] rx_i, ry_i;
		logic [DIV_W-1:0] trial;
		logic             gex, gey;

		if (k == 0) begin : g_first
			assign vld_i = sr_vld_s[CW-1];
			assign it_i  = sr_it_s[CW-1];
			assign len_i = sr_root_s[CW-1];
			assign rx_i  = sr_numx_s[CW-1];
			assign ry_i  = sr_numy_s[CW-1];
			assign qx_i  = '0;
			assign qy_i  = '0;
		end else begin : g_next
			assign vld_i = dv_vld_s[k-1];
			assign it_i  = dv_it_s[k-1];
			assign len_i = dv_len_s[k-1];
			assign rx_i  = dv_rx_s[k-1];
			assign ry_i  = dv_ry_s[k-1];
			assign qx_i  = dv_qx_s[k-1];
			assign qy_i  = dv_qy_s[k-1];
		end

		assign trial = DIV_W'(len_i) << B;
		assign gex   = DIV_W'(rx_i) >= trial;
		assign gey   = DIV_W'(ry_i) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[k] <= 1'b0;
			else if (en)
				dv_vld_s[k] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_it_s[k]  <= it_i;
				dv_len_s[k] <= len_i;
				dv_rx_s[k]  <= gex ? (rx_i - trial[NUM_W-1:0]) : rx_i;
				dv_ry_s[k]  <= gey ? (ry_i - trial[NUM_W-1:0]) : ry_i;
				dv_qx_s[k]  <= gex ? (qx_i | (CW'(1) << B)) : qx_i;
				dv_qy_s[k]  <= gey ? (qy_i | (CW'(1) << B)) : qy_i;
			end
		end
	end

	// clip, restore sign, pick scaled or original
	function automatic logic [CW:0] fit(input logic [CW-1:0] q, input logic neg);
		logic [CW-1:0] m;
		logic          s;
		begin
			m = q;
			s = 1'b0;
			if (!neg && q > HALF - CW'(1)) begin
				m = HALF - CW'(1);
				s = 1'b1;
			end else if (neg && q > HALF) begin
				m = HALF;
				s = 1'b1;
			end
			fit = {s, neg ? (~m + CW'(1)) : m};
		end
	endfunction

	item_t it_l;
	logic [CW:0] fx, fy;
	res_t  pd;
	logic  pv;

	assign it_l = dv_it_s[CW-1];
	assign fx   = fit(dv_qx_s[CW-1], it_l.nx);
	assign fy   = fit(dv_qy_s[CW-1], it_l.ny);
	assign pv   = dv_vld_s[CW-1] && en;

	always_comb begin
		pd.act = it_l.act;
		case (it_l.act)
			ACT_SHRINK, ACT_GROW: begin
				pd.x   = fx[CW-1:0];
				pd.y   = fy[CW-1:0];
				pd.sat = fx[CW] | fy[CW];
			end
			default: begin
				pd.x   = it_l.x;
				pd.y   = it_l.y;
				pd.sat = 1'b0;
			end
		endcase
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || vec_out.ready) begin
			out_vld_q  <= skid_vld_q || pv;
			skid_vld_q <= 1'b0;
		end else if (pv) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || vec_out.ready)
			out_data_q <= skid_vld_q ? skid_data_q : pd;
		else if (pv)
			skid_data_q <= pd;
	end

	assign vec_out.valid     = out_vld_q;
	assign vec_out.out_x     = out_data_q.x;
	assign vec_out.out_y     = out_data_q.y;
	assign vec_out.action    = out_data_q.act;
	assign vec_out.saturated = out_data_q.sat;
endmodule
`default_nettype wire

// ===== src/vll_checker.sv =====
// Port checker of the vector length limiter and its bind
`default_nettype none
`include "vec2_length_limit_defines.svh"
module vll_checker import vll_pkg::*; (
	input wire          clk,
	input wire          arst_n,
	input wire          in_ready,
	input wire          out_valid,
	input wire          out_ready,
	input wire [CW-1:0] out_x,
	input wire [CW-1:0] out_y,
	input wire [1:0]    action,
	input wire          saturated
);
	`VLL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(action) && $stable(saturated), "stalled result changed")
	`VLL_ASSERT_NOW(a_in_stall, clk, arst_n, !in_ready, $past(out_valid && !out_ready), "input held without output stall")
	`VLL_ASSERT_NOW(a_zero_vec, clk, arst_n, out_valid && action == ACT_ZERO, out_x == '0 && out_y == '0 && !saturated, "zero vector result not zero")
	`VLL_ASSERT_NOW(a_sat_act, clk, arst_n, out_valid && saturated, action == ACT_SHRINK || action == ACT_GROW, "saturation on unscaled vector")
endmodule

bind vec2_length_limit vll_checker u_vll_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (vec_in.ready),
	.out_valid (vec_out.valid),
	.out_ready (vec_out.ready),
	.out_x     (vec_out.out_x),
	.out_y     (vec_out.out_y),
	.action    (vec_out.action),
	.saturated (vec_out.saturated)
);
`default_nettype wire

// ===== sim/vll_tb_ifs.sv =====
// Simulation build entry: the channel interfaces are compiled from the source folder
`default_nettype none
`default_nettype wire

// ===== sim/vec2_length_limit_tb.sv =====
// Self-checking testbench of the 2D vector length limiter: random bursts against a predictor
`default_nettype none
module vec2_length_limit_tb;
	import vll_pkg::*;

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} vec_t;

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		action_t       act;
		logic          sat;
	} clamp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vll_in_if  vec_in ();
	vll_out_if vec_out ();
	vll_cfg_if cfg ();

	vec2_length_limit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vec_in  (vec_in.sink),
		.vec_out (vec_out.source),
		.cfg     (cfg.sink)
	);

	always #2 clk = ~clk;

	logic [LIM_W-1:0] lim_max = MAX_RESET;
	logic [LIM_W-1:0] lim_min = '0;

	vec_t   pending_q[$];
	clamp_t clamped_q[$];
	int     mismatches = 0;
	int     unexpected = 0;
	bit     gate_open = 1'b0;
	int     burst_left = 0;
	int     gap_left = 0;
	int     stall_phase = 0;

	function automatic logic [63:0] isqrt(logic [127:0] s);
		logic [63:0]  r;
		logic [63:0]  c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] scale(logic [CW-1:0] mag, logic neg,
		logic [LIM_W-1:0] lim, logic [63:0] len, ref logic sat);
		logic [127:0] q;
		q = ({96'd0, mag} * {97'd0, lim}) / {64'd0, len};
		if (!neg && q > 128'h7FFF_FFFF) begin
			q = 128'h7FFF_FFFF;
			sat = 1'b1;
		end else if (neg && q > 128'h8000_0000) begin
			q = 128'h8000_0000;
			sat = 1'b1;
		end
		return neg ? CW'(-q[CW-1:0]) : q[CW-1:0];
	endfunction

	function automatic clamp_t predict_clamp(vec_t v);
		clamp_t       r;
		logic         nx, ny, sat;
		logic [CW-1:0] mx, my;
		logic [127:0] s, maxsq, minsq;
		logic [63:0]  len;
		nx = v.x[CW-1];
		ny = v.y[CW-1];
		mx = nx ? -v.x : v.x;
		my = ny ? -v.y : v.y;
		s = {96'd0, mx} * {96'd0, mx} + {96'd0, my} * {96'd0, my};
		maxsq = {97'd0, lim_max} * {97'd0, lim_max};
		minsq = {97'd0, lim_min} * {97'd0, lim_min};
		sat = 1'b0;
		r.x = v.x;
		r.y = v.y;
		r.act = ACT_KEEP;
		if (s > maxsq) begin
			len = isqrt(s);
			r.x = scale(mx, nx, lim_max, len, sat);
			r.y = scale(my, ny, lim_max, len, sat);
			r.act = ACT_SHRINK;
		end else if (s < minsq) begin
			if (s == 0) begin
				r.act = ACT_ZERO;
			end else begin
				len = isqrt(s);
				r.x = scale(mx, nx, lim_min, len, sat);
				r.y = scale(my, ny, lim_min, len, sat);
				r.act = ACT_GROW;
			end
		end
		r.sat = sat;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (vec_in.valid && vec_in.ready) begin
			clamped_q.push_back(predict_clamp(pending_q.pop_front()));
		end
		if (!(vec_in.valid && !vec_in.ready)) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end
			if (gate_open && pending_q.size() > 0 && gap_left == 0) begin
				vec_in.valid <= 1'b1;
				vec_in.in_x <= pending_q[0].x;
				vec_in.in_y <= pending_q[0].y;
				burst_left--;
			end else begin
				vec_in.valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		clamp_t e;
		if (vec_out.valid && vec_out.ready) begin
			if (clamped_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected result x=%h y=%h", vec_out.out_x, vec_out.out_y);
			end else begin
				e = clamped_q.pop_front();
				if (vec_out.out_x !== e.x || vec_out.out_y !== e.y ||
						vec_out.action !== e.act || vec_out.saturated !== e.sat) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("mismatch exp %h %h %0d %b got %h %h %0d %b",
							e.x, e.y, e.act, e.sat, vec_out.out_x, vec_out.out_y,
							vec_out.action, vec_out.saturated);
				end
			end
		end
		stall_phase = (stall_phase + 1) % 97;
		vec_out.ready <= (stall_phase < 30) ? 1'b1 :
			(stall_phase < 60) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) == 1);
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_MAX_LENGTH)
			lim_max = val[LIM_W-1:0];
		else
			lim_min = val[LIM_W-1:0];
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || vec_in.valid || clamped_q.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_comp(int shift);
		return $urandom() >> shift | (($urandom_range(0, 1)) ? {CW{1'b1}} << (CW - shift) : '0);
	endfunction

	task automatic add_vec(logic [CW-1:0] x, logic [CW-1:0] y);
		vec_t v;
		v.x = x;
		v.y = y;
		pending_q.push_back(v);
	endtask

	task automatic add_random(int n);
		int sh;
		for (int i = 0; i < n; i++) begin
			sh = $urandom_range(0, 31);
			case ($urandom_range(0, 5))
				0: add_vec('0, '0);
				1: add_vec($urandom(), $urandom());
				2: add_vec(rand_comp(sh), '0);
				default: add_vec(rand_comp(sh), rand_comp($urandom_range(0, 31)));
			endcase
		end
	endtask

	initial begin
		logic [CFG_DAT_W-1:0] a, b;
		vec_in.valid = 1'b0;
		vec_in.in_x = '0;
		vec_in.in_y = '0;
		vec_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_MAX_LENGTH;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset limits, then tight ones with grow cases
		add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_vec(32'h8000_0000, 32'h8000_0000);
		add_vec(32'h8000_0000, 32'h0);
		add_vec(32'h0, 32'h0);
		add_vec(32'h0001_0000, 32'hFFFF_0000);
		gate_open = 1'b1;
		drain();
		write_reg(REG_MAX_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_MIN_LENGTH, 32'h8000_0000);
		drain();
		write_reg(REG_MAX_LENGTH, 32'h0010_0000);
		write_reg(REG_MIN_LENGTH, 32'h7FFF_FFFF);
		add_vec(32'h0, 32'h0);
		add_vec(32'h1, 32'h0);
		add_vec(32'hFFFF_FFFF, 32'h1);
		add_vec(32'h0008_0000, 32'hFFF8_0000);
		add_vec(32'h7FFF_FFFF, 32'h8000_0000);
		drain();
		write_reg(REG_MAX_LENGTH, 32'h7FFF_FFFF);
		add_vec(32'h0, 32'h1);
		add_vec(32'h8000_0000, 32'h1);
		add_vec(32'h3, 32'hFFFF_FFFC);
		drain();
		write_reg(REG_MAX_LENGTH, 32'h0);
		write_reg(REG_MIN_LENGTH, 32'h0);
		add_vec(32'h0, 32'h0);
		add_vec(32'h1, 32'h1);
		add_vec(32'h5555_AAAA, 32'hAAAA_5555);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			a = $urandom();
			b = (ph % 3 == 0) ? $urandom() : $urandom() >> $urandom_range(0, 30);
			write_reg(REG_MAX_LENGTH, a >> $urandom_range(0, 30));
			write_reg(REG_MIN_LENGTH, b);
			add_random(200);
			drain();
		end
		if (mismatches == 0 && unexpected == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
